FILE: design/mp2d_pkg.sv
// Shared types, register codes and constants for the streaming max-pool block.
// No dependencies; used by every module of the block.
`default_nettype none

package mp2d_pkg;

	// default sizing for the top level parameters
	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_MAX_KERNEL  = 8;
	localparam int DEF_SAMPLE_BITS = 16;

	// fixed limits on frame height and channel count
	localparam int DIM_LIMIT = 1024;

	// field widths
	localparam int CFG_BITS   = 11;
	localparam int IDX_BITS   = 3;
	localparam int KREG_BITS  = 4;
	localparam int COORD_BITS = 10;
	localparam int OFS_BITS   = 3;
	localparam int POOL_BITS  = 15;
	localparam int CLAMP_BITS = 13;

	// register values after reset
	localparam int RST_KERNEL   = 2;
	localparam int RST_FRAME    = 64;
	localparam int RST_CHANNELS = 1;

	// configuration register indexes
	typedef enum logic [IDX_BITS-1:0] {
		REG_KERNEL_X      = 3'd0,
		REG_KERNEL_Y      = 3'd1,
		REG_FRAME_WIDTH   = 3'd2,
		REG_FRAME_HEIGHT  = 3'd3,
		REG_CHANNEL_COUNT = 3'd4
	} cfg_reg_t;

	// window position of one sample, from the position tracker to the datapath
	typedef struct packed {
		logic                  in_win;
		logic                  first;
		logic                  last;
		logic [OFS_BITS-1:0]   dx;
		logic [OFS_BITS-1:0]   dy;
		logic [COORD_BITS-1:0] wy;
		logic [COORD_BITS-1:0] chan;
	} win_tag_t;

	// zero acts as one, values above hi saturate at hi
	function automatic logic [CLAMP_BITS-1:0] clamp_dim(input logic [CFG_BITS-1:0] v,
			input logic [CLAMP_BITS-1:0] hi);
		logic [CLAMP_BITS-1:0] ext;
		ext = CLAMP_BITS'(v);
		if (v == '0) begin
			return CLAMP_BITS'(1);
		end else if (ext > hi) begin
			return hi;
		end else begin
			return ext;
		end
	endfunction

endpackage

`default_nettype wire

FILE: design/max_pool_2d_stream.sv
// Top level of the streaming 2-D max-pool block.
// Depends on mp2d_pkg, mp2d_pos and mp2d_core.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  sample   | sample_valid/sample_ready | sample
//  result   | result_valid/result_ready | pooled, out_col, out_row, out_chan,
//           |                           | winner_dx, winner_dy, winner_valid
//  config   | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// One sample is accepted per cycle while the input is not stalled; the sample that
// closes a window passes through one compare stage and one result register.
// The partial-max memory is read on accept and written when stage 1 advances, with a
// one-entry bypass for back-to-back samples of the same window column.
// Reset restores the register defaults and zeroes the position; the memory has
// no clearing pass. Input stalls only when a result waits and another is due.
`default_nettype none

module max_pool_2d_stream #(
	parameter int MAX_WIDTH   = mp2d_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL  = mp2d_pkg::DEF_MAX_KERNEL,
	parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            sample_valid,
	output logic                                 sample_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]   sample,
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output logic [mp2d_pkg::POOL_BITS-1:0]       pooled,
	output logic [mp2d_pkg::COORD_BITS-1:0]      out_col,
	output logic [mp2d_pkg::COORD_BITS-1:0]      out_row,
	output logic [mp2d_pkg::COORD_BITS-1:0]      out_chan,
	output logic [mp2d_pkg::OFS_BITS-1:0]        winner_dx,
	output logic [mp2d_pkg::OFS_BITS-1:0]        winner_dy,
	output logic                                 winner_valid,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [mp2d_pkg::IDX_BITS-1:0]   cfg_index,
	input  wire logic [mp2d_pkg::CFG_BITS-1:0]   cfg_data
);
	import mp2d_pkg::*;

	win_tag_t                     tag;
	logic [$clog2(MAX_WIDTH)-1:0] wx;
	logic                         step;

	// register writes are always accepted
	assign cfg_ready = 1'b1;
	assign step      = sample_valid && sample_ready;

	mp2d_pos #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_KERNEL (MAX_KERNEL)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.tag       (tag),
		.wx        (wx)
	);

	mp2d_core #(
		.MAX_WIDTH   (MAX_WIDTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.tag          (tag),
		.wx           (wx),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.pooled       (pooled),
		.out_col      (out_col),
		.out_row      (out_row),
		.out_chan     (out_chan),
		.winner_dx    (winner_dx),
		.winner_dy    (winner_dy),
		.winner_valid (winner_valid)
	);

endmodule

`default_nettype wire

FILE: design/mp2d_pos.sv
// Configuration registers and frame position tracking for the max-pool block.
// Depends on mp2d_pkg; tracks window coordinates incrementally, no dividers.
`default_nettype none

module mp2d_pos #(
	parameter int MAX_WIDTH  = mp2d_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL = mp2d_pkg::DEF_MAX_KERNEL
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	input  wire logic [mp2d_pkg::IDX_BITS-1:0]     cfg_index,
	input  wire logic [mp2d_pkg::CFG_BITS-1:0]     cfg_data,
	input  wire logic                              step,
	output mp2d_pkg::win_tag_t                     tag,
	output logic [$clog2(MAX_WIDTH)-1:0]           wx
);
	import mp2d_pkg::*;

	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int WB       = $clog2(MAX_WIDTH + 1);
	localparam int KB       = $clog2(MAX_KERNEL + 1);
	localparam int DXB      = $clog2(MAX_KERNEL);
	localparam int CB       = $clog2(DIM_LIMIT + 1);
	localparam int RB       = $clog2(DIM_LIMIT);
	localparam int SB       = (WB > KB ? WB : KB) + 1;
	localparam int RSB      = (CB > KB ? CB : KB) + 1;

	// clamped configuration
	logic [KB-1:0]       kx_q, ky_q;
	logic [WB-1:0]       w_q;
	logic [CB-1:0]       h_q, c_q;

	// position of the next sample
	logic [COL_BITS-1:0] col_q, wx_q, base_q;
	logic [DXB-1:0]      dx_q, dy_q;
	logic [RB-1:0]       row_q, wy_q, rbase_q, chan_q;

	logic col_end, row_end, chan_end, dx_end, dy_end, cfg_hit;

	// end-of-run detection
	assign col_end  = (WB'(col_q) + WB'(1)) >= w_q;
	assign row_end  = (CB'(row_q) + CB'(1)) >= h_q;
	assign chan_end = (CB'(chan_q) + CB'(1)) >= c_q;
	assign dx_end   = KB'(dx_q) == (kx_q - KB'(1));
	assign dy_end   = KB'(dy_q) == (ky_q - KB'(1));

	// a write to an index past the list changes nothing
	always_comb begin
		unique case (cfg_index)
			REG_KERNEL_X, REG_KERNEL_Y, REG_FRAME_WIDTH,
			REG_FRAME_HEIGHT, REG_CHANNEL_COUNT: cfg_hit = cfg_valid;
			default: cfg_hit = 1'b0;
		endcase
	end

	// tag for the sample now at the input
	always_comb begin
		tag.in_win = (SB'(base_q) + SB'(kx_q) <= SB'(w_q))
			&& (RSB'(rbase_q) + RSB'(ky_q) <= RSB'(h_q));
		tag.first  = (dx_q == '0) && (dy_q == '0);
		tag.last   = dx_end && dy_end;
		tag.dx     = OFS_BITS'(dx_q);
		tag.dy     = OFS_BITS'(dy_q);
		tag.wy     = COORD_BITS'(wy_q);
		tag.chan   = COORD_BITS'(chan_q);
	end
	assign wx = wx_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kx_q <= KB'(clamp_dim(CFG_BITS'(RST_KERNEL), CLAMP_BITS'(MAX_KERNEL)));
			ky_q <= KB'(clamp_dim(CFG_BITS'(RST_KERNEL), CLAMP_BITS'(MAX_KERNEL)));
			w_q  <= WB'(clamp_dim(CFG_BITS'(RST_FRAME), CLAMP_BITS'(MAX_WIDTH)));
			h_q  <= CB'(clamp_dim(CFG_BITS'(RST_FRAME), CLAMP_BITS'(DIM_LIMIT)));
			c_q  <= CB'(clamp_dim(CFG_BITS'(RST_CHANNELS), CLAMP_BITS'(DIM_LIMIT)));
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KERNEL_X: kx_q <= KB'(clamp_dim(CFG_BITS'(cfg_data[KREG_BITS-1:0]),
					CLAMP_BITS'(MAX_KERNEL)));
				REG_KERNEL_Y: ky_q <= KB'(clamp_dim(CFG_BITS'(cfg_data[KREG_BITS-1:0]),
					CLAMP_BITS'(MAX_KERNEL)));
				REG_FRAME_WIDTH: w_q <= WB'(clamp_dim(cfg_data, CLAMP_BITS'(MAX_WIDTH)));
				REG_FRAME_HEIGHT: h_q <= CB'(clamp_dim(cfg_data, CLAMP_BITS'(DIM_LIMIT)));
				REG_CHANNEL_COUNT: c_q <= CB'(clamp_dim(cfg_data, CLAMP_BITS'(DIM_LIMIT)));
				default: ;
			endcase
		end
	end

	// position counters: column fastest, then row, then channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			dx_q    <= '0;
			wx_q    <= '0;
			base_q  <= '0;
			row_q   <= '0;
			dy_q    <= '0;
			wy_q    <= '0;
			rbase_q <= '0;
			chan_q  <= '0;
		end else if (cfg_hit) begin
			col_q   <= '0;
			dx_q    <= '0;
			wx_q    <= '0;
			base_q  <= '0;
			row_q   <= '0;
			dy_q    <= '0;
			wy_q    <= '0;
			rbase_q <= '0;
			chan_q  <= '0;
		end else if (step) begin
			if (col_end) begin
				col_q  <= '0;
				dx_q   <= '0;
				wx_q   <= '0;
				base_q <= '0;
				if (row_end) begin
					row_q   <= '0;
					dy_q    <= '0;
					wy_q    <= '0;
					rbase_q <= '0;
					chan_q  <= chan_end ? '0 : chan_q + RB'(1);
				end else begin
					row_q <= row_q + RB'(1);
					if (dy_end) begin
						dy_q    <= '0;
						wy_q    <= wy_q + RB'(1);
						rbase_q <= rbase_q + RB'(ky_q);
					end else begin
						dy_q <= dy_q + DXB'(1);
					end
				end
			end else begin
				col_q <= col_q + COL_BITS'(1);
				if (dx_end) begin
					dx_q   <= '0;
					wx_q   <= wx_q + COL_BITS'(1);
					base_q <= base_q + COL_BITS'(kx_q);
				end else begin
					dx_q <= dx_q + DXB'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/mp2d_core.sv
// Max-pool datapath: partial-max memory, compare stage and result register.
// Depends on mp2d_pkg; takes window tags from mp2d_pos.
`default_nettype none

module mp2d_core #(
	parameter int MAX_WIDTH   = mp2d_pkg::DEF_MAX_WIDTH,
	parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                sample_valid,
	output logic                                     sample_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]       sample,
	input  mp2d_pkg::win_tag_t                       tag,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]        wx,
	output logic                                     result_valid,
	input  wire logic                                result_ready,
	output logic [mp2d_pkg::POOL_BITS-1:0]           pooled,
	output logic [mp2d_pkg::COORD_BITS-1:0]          out_col,
	output logic [mp2d_pkg::COORD_BITS-1:0]          out_row,
	output logic [mp2d_pkg::COORD_BITS-1:0]          out_chan,
	output logic [mp2d_pkg::OFS_BITS-1:0]            winner_dx,
	output logic [mp2d_pkg::OFS_BITS-1:0]            winner_dy,
	output logic                                     winner_valid
);
	import mp2d_pkg::*;

	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int MAG_BITS = SAMPLE_BITS - 1;
	localparam int WIN_BITS = 2 * OFS_BITS + 1;
	localparam int ENT_BITS = MAG_BITS + WIN_BITS;

	// entry: {valid, dy, dx, max}
	logic [ENT_BITS-1:0]    mem [MAX_WIDTH];

	// stage 1
	logic                   s1_valid;
	win_tag_t               tag_s1;
	logic [COL_BITS-1:0]    wx_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [ENT_BITS-1:0]    rd_s1;
	logic                   byp_s1;
	logic [ENT_BITS-1:0]    byp_ent_s1;

	// result register
	logic                   valid_s2;
	logic [POOL_BITS-1:0]   pooled_s2;
	logic [COORD_BITS-1:0]  col_s2, row_s2, chan_s2;
	logic [OFS_BITS-1:0]    dx_s2, dy_s2;
	logic                   wvalid_s2;

	logic [ENT_BITS-1:0]    prev_ent, new_ent;
	logic [MAG_BITS-1:0]    base_max, new_max;
	logic [WIN_BITS-1:0]    base_win, new_win;
	logic                   take, emit, s1_adv, accept;

	// running max update; previous beat's write is forwarded past the memory
	always_comb begin
		prev_ent = byp_s1 ? byp_ent_s1 : rd_s1;
		base_max = tag_s1.first ? '0 : prev_ent[MAG_BITS-1:0];
		base_win = tag_s1.first ? '0 : prev_ent[ENT_BITS-1:MAG_BITS];
		take     = !sample_s1[SAMPLE_BITS-1] && (sample_s1[MAG_BITS-1:0] >= base_max);
		new_max  = take ? sample_s1[MAG_BITS-1:0] : base_max;
		new_win  = take ? {1'b1, tag_s1.dy, tag_s1.dx} : base_win;
		new_ent  = {new_win, new_max};
	end

	// handshake: stage 1 stalls only on a result that cannot be placed
	assign emit         = tag_s1.in_win && tag_s1.last;
	assign s1_adv       = s1_valid && (!emit || !valid_s2 || result_ready);
	assign sample_ready = !s1_valid || s1_adv;
	assign accept       = sample_valid && sample_ready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
			if (s1_adv && emit) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// partial store: written on stage 1 advance of an in-window sample, read on accept
	always_ff @(posedge clk) begin
		if (s1_adv && tag_s1.in_win) begin
			mem[wx_s1] <= new_ent;
		end
		if (accept) begin
			rd_s1 <= mem[wx];
		end
	end

	// stage 1 payload and bypass
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1     <= tag;
			wx_s1      <= wx;
			sample_s1  <= sample;
			byp_s1     <= s1_adv && tag_s1.in_win && (wx_s1 == wx);
			byp_ent_s1 <= new_ent;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			pooled_s2 <= POOL_BITS'(new_max);
			col_s2    <= COORD_BITS'(wx_s1);
			row_s2    <= tag_s1.wy;
			chan_s2   <= tag_s1.chan;
			dx_s2     <= new_win[OFS_BITS-1:0];
			dy_s2     <= new_win[2*OFS_BITS-1:OFS_BITS];
			wvalid_s2 <= new_win[WIN_BITS-1];
		end
	end

	assign result_valid = valid_s2;
	assign pooled       = pooled_s2;
	assign out_col      = col_s2;
	assign out_row      = row_s2;
	assign out_chan     = chan_s2;
	assign winner_dx    = dx_s2;
	assign winner_dy    = dy_s2;
	assign winner_valid = wvalid_s2;

endmodule

`default_nettype wire

FILE: design/mp2d_checker.sv
// Port-level assertions for max_pool_2d_stream, attached by the bind below.
// Depends on mp2d_pkg for field widths.
`default_nettype none

module mp2d_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            sample_valid,
	input wire logic                            sample_ready,
	input wire logic                            result_valid,
	input wire logic                            result_ready,
	input wire logic [mp2d_pkg::POOL_BITS-1:0]  pooled,
	input wire logic [mp2d_pkg::OFS_BITS-1:0]   winner_dx,
	input wire logic [mp2d_pkg::OFS_BITS-1:0]   winner_dy,
	input wire logic                            winner_valid
);

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(pooled)
			&& $stable(winner_dx) && $stable(winner_dy) && $stable(winner_valid))
		else $error("result beat changed while stalled");

	// window with no winner reports zero pooled value and zero winner offsets
	a_no_winner: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !winner_valid |-> pooled == '0 && winner_dx == '0
			&& winner_dy == '0)
		else $error("no-winner result carries nonzero fields");

	// a fresh result comes from an accepted sample beat, through stage 1 and the result register
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_valid && sample_ready, 2))
		else $error("result appeared without a preceding sample beat");

	// input backpressure only when a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> result_valid && !result_ready)
		else $error("sample input stalled without a waiting result");

endmodule

bind max_pool_2d_stream mp2d_checker u_mp2d_checker (.*);

`default_nettype wire

FILE: tb/pool_checker.sv
// Checker for the streaming max-pool block: watches the config, sample and result channels.
// Predicts each pooled beat from its own copy of the state and compares field by field.
// Depends on mp2d_pkg for widths and register indexes.
`timescale 1ns / 1ps

module pool_checker
	import mp2d_pkg::*;
(
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               sample_valid,
	input  wire logic                               sample_ready,
	input  wire logic signed [DEF_SAMPLE_BITS-1:0]  sample,
	input  wire logic                               result_valid,
	input  wire logic                               result_ready,
	input  wire logic [POOL_BITS-1:0]               pooled,
	input  wire logic [COORD_BITS-1:0]              out_col,
	input  wire logic [COORD_BITS-1:0]              out_row,
	input  wire logic [COORD_BITS-1:0]              out_chan,
	input  wire logic [OFS_BITS-1:0]                winner_dx,
	input  wire logic [OFS_BITS-1:0]                winner_dy,
	input  wire logic                               winner_valid,
	input  wire logic                               cfg_valid,
	input  wire logic                               cfg_ready,
	input  wire logic [IDX_BITS-1:0]                cfg_index,
	input  wire logic [CFG_BITS-1:0]                cfg_data,
	output int                                      fail_count,
	output int                                      pending,
	output int                                      result_count
);

	localparam int PRINT_CAP = 200;

	typedef struct packed {
		logic [POOL_BITS-1:0]  pooled;
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
		logic [COORD_BITS-1:0] chan;
		logic [OFS_BITS-1:0]   dx;
		logic [OFS_BITS-1:0]   dy;
		logic                  hit;
	} pool_beat_t;

	pool_beat_t expected_pools[$];

	// register copies; kernels kept at KREG_BITS, the rest at the port width
	logic [KREG_BITS-1:0] kern_x_r, kern_y_r;
	logic [CFG_BITS-1:0]  width_r, height_r, chans_r;

	// position of the next sample
	int col_pos, row_pos, chan_pos;

	// running maximum and winner per window column
	int                  run_max [DEF_MAX_WIDTH];
	logic [OFS_BITS-1:0] run_dx  [DEF_MAX_WIDTH];
	logic [OFS_BITS-1:0] run_dy  [DEF_MAX_WIDTH];
	logic                run_hit [DEF_MAX_WIDTH];

	int errors = 0;
	int beats_seen;

	assign fail_count = errors;

	// zero acts as one, anything above the limit saturates
	function automatic int eff_dim(input int v, input int hi);
		if (v == 0) return 1;
		return (v > hi) ? hi : v;
	endfunction

	task automatic report(input string msg);
		if (errors < PRINT_CAP) $display("[%0t] pooled beat mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) report($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	// register write: any valid index restarts the frame position
	task automatic apply_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
		case (idx)
			REG_KERNEL_X:      kern_x_r = data[KREG_BITS-1:0];
			REG_KERNEL_Y:      kern_y_r = data[KREG_BITS-1:0];
			REG_FRAME_WIDTH:   width_r  = data;
			REG_FRAME_HEIGHT:  height_r = data;
			REG_CHANNEL_COUNT: chans_r  = data;
			default:           return;
		endcase
		col_pos  = 0;
		row_pos  = 0;
		chan_pos = 0;
	endtask

	// one accepted sample: update the window column, queue a beat if the window closes
	task automatic predict_pool(input logic signed [DEF_SAMPLE_BITS-1:0] s);
		int kx, ky, w, h, c;
		int wx, wy, dx, dy, cur;
		logic [OFS_BITS-1:0] bdx, bdy;
		logic bhit;
		pool_beat_t beat;
		kx = eff_dim(int'(kern_x_r), DEF_MAX_KERNEL);
		ky = eff_dim(int'(kern_y_r), DEF_MAX_KERNEL);
		w  = eff_dim(int'(width_r), DEF_MAX_WIDTH);
		h  = eff_dim(int'(height_r), DIM_LIMIT);
		c  = eff_dim(int'(chans_r), DIM_LIMIT);
		if (col_pos < (w / kx) * kx && row_pos < (h / ky) * ky) begin
			wx = col_pos / kx;
			dx = col_pos % kx;
			wy = row_pos / ky;
			dy = row_pos % ky;
			cur  = 0;
			bdx  = '0;
			bdy  = '0;
			bhit = 1'b0;
			// first sample of a window starts from zero with no winner
			if (dx != 0 || dy != 0) begin
				cur  = run_max[wx];
				bdx  = run_dx[wx];
				bdy  = run_dy[wx];
				bhit = run_hit[wx];
			end
			// ties go to the later sample
			if (int'(s) >= cur) begin
				cur  = int'(s);
				bdx  = OFS_BITS'(dx);
				bdy  = OFS_BITS'(dy);
				bhit = 1'b1;
			end
			run_max[wx] = cur;
			run_dx[wx]  = bdx;
			run_dy[wx]  = bdy;
			run_hit[wx] = bhit;
			if (dx == kx - 1 && dy == ky - 1) begin
				beat.pooled = POOL_BITS'(cur);
				beat.col    = COORD_BITS'(wx);
				beat.row    = COORD_BITS'(wy);
				beat.chan   = COORD_BITS'(chan_pos);
				beat.dx     = bdx;
				beat.dy     = bdy;
				beat.hit    = bhit;
				expected_pools.push_back(beat);
			end
		end
		// advance position; trailing columns and rows only move it on
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h) begin
				row_pos = 0;
				chan_pos++;
				if (chan_pos >= c) chan_pos = 0;
			end
		end
	endtask

	task automatic check_beat();
		pool_beat_t want;
		if (expected_pools.size() == 0) begin
			report("result beat with nothing expected");
			return;
		end
		want = expected_pools.pop_front();
		check_field("pooled", 32'(pooled), 32'(want.pooled));
		check_field("out_col", 32'(out_col), 32'(want.col));
		check_field("out_row", 32'(out_row), 32'(want.row));
		check_field("out_chan", 32'(out_chan), 32'(want.chan));
		check_field("winner_dx", 32'(winner_dx), 32'(want.dx));
		check_field("winner_dy", 32'(winner_dy), 32'(want.dy));
		check_field("winner_valid", 32'(winner_valid), 32'(want.hit));
	endtask

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_x_r = KREG_BITS'(RST_KERNEL);
			kern_y_r = KREG_BITS'(RST_KERNEL);
			width_r  = CFG_BITS'(RST_FRAME);
			height_r = CFG_BITS'(RST_FRAME);
			chans_r  = CFG_BITS'(RST_CHANNELS);
			col_pos  = 0;
			row_pos  = 0;
			chan_pos = 0;
			beats_seen = 0;
			expected_pools.delete();
			pending      <= 0;
			result_count <= 0;
		end else begin
			if (result_valid && result_ready) begin
				beats_seen++;
				check_beat();
			end
			if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
			if (sample_valid && sample_ready) predict_pool(sample);
			pending      <= expected_pools.size();
			result_count <= beats_seen;
		end
	end

endmodule

FILE: tb/tb.sv
// Testbench top for the streaming max-pool block: clock, reset, stimulus and verdict.
// Drives config, sample and result channels; pool_checker does prediction and compare.
// Depends on mp2d_pkg, max_pool_2d_stream and pool_checker.
`timescale 1ns / 1ps

module tb;
	import mp2d_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int ITEM_TARGET    = 500;
	localparam int RESULT_TARGET  = 48;
	// index outside the register map, must be ignored
	localparam logic [IDX_BITS-1:0] REG_SPARE = 3'd7;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                              sample_valid = 1'b0;
	logic                              sample_ready;
	logic signed [DEF_SAMPLE_BITS-1:0] sample       = '0;
	logic                              result_valid;
	logic                              result_ready = 1'b0;
	logic [POOL_BITS-1:0]              pooled;
	logic [COORD_BITS-1:0]             out_col, out_row, out_chan;
	logic [OFS_BITS-1:0]               winner_dx, winner_dy;
	logic                              winner_valid;
	logic                              cfg_valid    = 1'b0;
	logic                              cfg_ready;
	logic [IDX_BITS-1:0]               cfg_index    = '0;
	logic [CFG_BITS-1:0]               cfg_data     = '0;

	int fail_count, pending, result_count;
	int sent_count  = 0;
	int idle_cycles = 0;
	int last_val    = 0;
	bit hold_req    = 1'b0;
	bit hold_active = 1'b0;
	bit no_idle     = 1'b0;

	// two channels on a 3x3 frame with 2x2 windows, then a few beats past the wrap:
	// all-negative window, extremes, ties, trailing column and row
	int directed_vals [23] = '{
		-32768, -1, 5, -2, -300, 7, 100, 200, 300,
		32767, 0, -5, 32767, 32767, 1, 0, 0, 0,
		0, 0, -7, -1, 0
	};

	always #5 clk = ~clk;

	max_pool_2d_stream dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.pooled       (pooled),
		.out_col      (out_col),
		.out_row      (out_row),
		.out_chan     (out_chan),
		.winner_dx    (winner_dx),
		.winner_dy    (winner_dy),
		.winner_valid (winner_valid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	pool_checker pool_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.pooled       (pooled),
		.out_col      (out_col),
		.out_row      (out_row),
		.out_chan     (out_chan),
		.winner_dx    (winner_dx),
		.winner_dy    (winner_dy),
		.winner_valid (winner_valid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count)
	);

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_sample();
		int r, v;
		r = $urandom_range(0, 99);
		if (r < 8) v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
		else if (r < 22) v = last_val;
		else if (r < 42) v = -int'($urandom_range(1, 500));
		else if (r < 55) v = 0;
		else if (r < 70) v = int'($urandom_range(0, 500));
		else v = int'($signed(16'($urandom)));
		last_val = v;
		return v;
	endfunction

	// kernel register value, out of range now and then
	function automatic int pick_kernel();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return 0;
		if (r < 14) return $urandom_range(9, 15);
		if (r < 30) return DEF_MAX_KERNEL;
		return $urandom_range(1, 4);
	endfunction

	function automatic int pick_frame(input int k);
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 0;
		if (r < 10) return $urandom_range(DEF_MAX_WIDTH, 2047);
		if (r < 15) return 1;
		return k * $urandom_range(1, 4) + $urandom_range(0, 2);
	endfunction

	function automatic int pick_chans();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 0;
		if (r < 10) return ($urandom_range(0, 1) != 0) ? DIM_LIMIT : 2047;
		return $urandom_range(1, 3);
	endfunction

	// one config beat; caller lowers cfg_valid after the last one
	task automatic write_reg(input logic [IDX_BITS-1:0] idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_BITS'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic program_regs(input int kx, input int ky, input int w, input int h,
			input int c);
		write_reg(REG_KERNEL_X, kx);
		write_reg(REG_KERNEL_Y, ky);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_CHANNEL_COUNT, c);
		cfg_valid <= 1'b0;
	endtask

	// one sample beat, valid held until accepted
	task automatic push_sample(input int v);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= DEF_SAMPLE_BITS'(v);
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		sent_count++;
	endtask

	// wait out every expected beat, then let the block settle
	task automatic wait_drained();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase();
		int kx, ky, kxe, kye, w, we, h, c, n;
		kx  = pick_kernel();
		ky  = pick_kernel();
		kxe = (kx == 0) ? 1 : ((kx > DEF_MAX_KERNEL) ? DEF_MAX_KERNEL : kx);
		kye = (ky == 0) ? 1 : ((ky > DEF_MAX_KERNEL) ? DEF_MAX_KERNEL : ky);
		w   = pick_frame(kxe);
		h   = pick_frame(kye);
		c   = pick_chans();
		// random subset; no write at all keeps the position running on
		if ($urandom_range(0, 9) < 8) write_reg(REG_KERNEL_X, kx);
		if ($urandom_range(0, 9) < 8) write_reg(REG_KERNEL_Y, ky);
		if ($urandom_range(0, 9) < 8) write_reg(REG_FRAME_WIDTH, w);
		if ($urandom_range(0, 9) < 8) write_reg(REG_FRAME_HEIGHT, h);
		if ($urandom_range(0, 9) < 8) write_reg(REG_CHANNEL_COUNT, c);
		if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, $urandom_range(0, 2047));
		cfg_valid <= 1'b0;
		we = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
		n  = we * kye * $urandom_range(1, 2) + $urandom_range(0, 8);
		if (n > 150) n = $urandom_range(20, 150);
		no_idle = ($urandom_range(0, 4) == 0);
		repeat (n) push_sample(pick_sample());
		wait_drained();
		no_idle = 1'b0;
	endtask

	// result side: random ready, one long hold-off on request
	initial begin : result_sink
		int run, gap;
		bit hold_done;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				hold_active = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
				hold_done   = 1'b1;
			end else begin
				run = $urandom_range(1, 12);
				result_ready <= 1'b1;
				repeat (run) @(posedge clk);
				gap = no_idle ? 0 : pick_gap();
				if (gap > 0) begin
					result_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// watchdog: cycles with no beat on any channel
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: small frame, two channels, wrap back to channel 0
		program_regs(2, 2, 3, 3, 2);
		foreach (directed_vals[i]) push_sample(directed_vals[i]);
		wait_drained();

		// 1x1 windows while the result side holds off: input must back up
		program_regs(1, 1, 16, 4, 2);
		no_idle  = 1'b1;
		hold_req = 1'b1;
		wait (hold_active);
		@(posedge clk);
		repeat (80) push_sample(pick_sample());
		wait_drained();
		no_idle = 1'b0;

		// largest window, one trailing column
		program_regs(DEF_MAX_KERNEL, DEF_MAX_KERNEL, 9, 8, 1);
		repeat (72) push_sample(pick_sample());
		wait_drained();

		while (sent_count < ITEM_TARGET || result_count < RESULT_TARGET) random_phase();

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
